[design/gra_pkg.sv]
// Shared types, constants and helper functions of the guillotine rectangle allocator.
`default_nettype none
package gra_pkg;

  localparam int COORD_W = 15;
  localparam int DATA_W = 32;
  localparam int CFG_AW = 3;
  localparam int MAX_TILES_DEF = 64;
  localparam logic [COORD_W-1:0] COORD_MAX = 15'd16384;
  localparam logic [COORD_W-1:0] ATLAS_RESET = 15'd4096;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    REG_ATLAS_W = 1'b0,
    REG_ATLAS_H = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SPLIT,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t    op;
    coord_t req_width;
    coord_t req_height;
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
  } req_t;

  typedef struct packed {
    coord_t  out_left;
    coord_t  out_top;
    coord_t  out_right;
    coord_t  out_bottom;
    status_t status;
  } res_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } tile_t;

  typedef struct packed {
    coord_t atlas_width;
    coord_t atlas_height;
  } cfg_t;

  function automatic coord_t clamp_coord(input coord_t v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic coord_t span(input coord_t lo, input coord_t hi);
    return (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

endpackage
`default_nettype wire

[design/gra_regs.sv]
// Configuration register file holding the atlas size, reached through the APB port.
`default_nettype none
module gra_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gra_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [gra_pkg::DATA_W-1:0]  pwdata,
  output logic      [gra_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output gra_pkg::cfg_t                    cfg
);
  import gra_pkg::*;

  coord_t   atlas_w_r;
  coord_t   atlas_h_r;
  reg_idx_t idx;
  coord_t   wval;
  coord_t   rval;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1]);
  assign wval   = clamp_coord(pwdata[COORD_W-1:0]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= ATLAS_RESET;
      atlas_h_r <= ATLAS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ATLAS_W: atlas_w_r <= wval;
        REG_ATLAS_H: atlas_h_r <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ATLAS_W: rval = atlas_w_r;
      REG_ATLAS_H: rval = atlas_h_r;
      default:     rval = '0;
    endcase
  end

  assign prdata           = {{(DATA_W-COORD_W){1'b0}}, rval};
  assign cfg.atlas_width  = atlas_w_r;
  assign cfg.atlas_height = atlas_h_r;

endmodule
`default_nettype wire

[design/gra_tile_mem.sv]
// Free-tile table: one write port and one read port with registered read data.
`default_nettype none
module gra_tile_mem #(
  parameter int MAX_TILES = gra_pkg::MAX_TILES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_TILES)-1:0]  rd_addr,
  output gra_pkg::tile_t                     rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_TILES)-1:0]  wr_addr,
  input  wire gra_pkg::tile_t                wr_data
);
  import gra_pkg::*;

  tile_t mem [MAX_TILES];
  tile_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[design/gra_ctrl.sv]
// Request sequencer: scans the tile table, edits the hit entry and registers the result.
`default_nettype none
module gra_ctrl #(
  parameter int MAX_TILES = gra_pkg::MAX_TILES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gra_pkg::req_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gra_pkg::res_t                      out_data,
  input  wire gra_pkg::cfg_t                 cfg,
  output logic                               rd_en,
  output logic [$clog2(MAX_TILES)-1:0]       rd_addr,
  input  wire gra_pkg::tile_t                rd_data,
  output logic                               wr_en,
  output logic [$clog2(MAX_TILES)-1:0]       wr_addr,
  output gra_pkg::tile_t                     wr_data
);
  import gra_pkg::*;

  localparam int IW = $clog2(MAX_TILES);
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TILES);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  req_t            req_r, req_nxt;
  logic [IW-1:0]   scan_idx_r, scan_idx_nxt;
  logic            scan_more_r, scan_more_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  tile_t           tile_r, tile_nxt;
  res_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_data_r, out_data_nxt;

  coord_t tw, th, top_cut, left_cut;
  logic   fits, w_eq, h_eq, full;

  assign tw       = span(rd_data.left, rd_data.right);
  assign th       = span(rd_data.top, rd_data.bottom);
  assign fits     = (req_r.req_width <= tw) && (req_r.req_height <= th);
  assign w_eq     = (req_r.req_width == tw);
  assign h_eq     = (req_r.req_height == th);
  assign top_cut  = coord_t'(rd_data.top + req_r.req_height);
  assign left_cut = coord_t'(rd_data.left + req_r.req_width);
  assign full     = (count_r >= MAX_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      count_r     <= CW'(1);
      scan_more_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_more_r <= scan_more_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    tile_r     <= tile_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    scan_idx_nxt  = scan_idx_r;
    scan_more_nxt = scan_more_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_idx_nxt   = hit_idx_r;
    tile_nxt      = tile_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_idx_r;
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_data       = tile_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_BOOT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = '{left: '0, top: '0, right: cfg.atlas_width, bottom: cfg.atlas_height};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt        = in_data;
          res_nxt        = '0;
          res_nxt.status = ST_OK;
          state_nxt      = S_RESP;
          unique case (in_data.op)
            OP_ALLOC: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NO_FIT;
              end else begin
                scan_idx_nxt  = IW'(count_r - 1'b1);
                scan_more_nxt = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            OP_FREE: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = IW'(count_r);
                wr_data.left   = clamp_coord(in_data.rect_left);
                wr_data.top    = clamp_coord(in_data.rect_top);
                wr_data.right  = clamp_coord(in_data.rect_right);
                wr_data.bottom = clamp_coord(in_data.rect_bottom);
                count_nxt      = count_r + 1'b1;
              end
            end
            OP_INIT: begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = '{left: '0, top: '0, right: cfg.atlas_width,
                            bottom: cfg.atlas_height};
              count_nxt = CW'(1);
            end
            OP_NOP: ;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rd_en   = scan_more_r;
        rd_addr = scan_idx_r;
        if (scan_more_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_idx_r;
          if (scan_idx_r == '0) begin
            scan_more_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r - 1'b1;
          end
        end
        if (rd_vld_r) begin
          if (fits) begin
            hit_idx_nxt        = rd_idx_r;
            state_nxt          = S_RESP;
            res_nxt.out_left   = rd_data.left;
            res_nxt.out_top    = rd_data.top;
            res_nxt.out_right  = rd_data.right;
            res_nxt.out_bottom = rd_data.bottom;
            res_nxt.status     = ST_OK;
            priority if (w_eq && h_eq) begin
              state_nxt = S_MOVE_RD;
            end else if (w_eq) begin
              wr_en              = 1'b1;
              wr_addr            = rd_idx_r;
              wr_data            = rd_data;
              wr_data.top        = top_cut;
              res_nxt.out_bottom = top_cut;
            end else if (h_eq) begin
              wr_en             = 1'b1;
              wr_addr           = rd_idx_r;
              wr_data           = rd_data;
              wr_data.left      = left_cut;
              res_nxt.out_right = left_cut;
            end else if (full) begin
              res_nxt        = '0;
              res_nxt.status = ST_FULL;
            end else begin
              wr_en              = 1'b1;
              wr_addr            = IW'(count_r);
              wr_data            = '{left: rd_data.left, top: top_cut, right: left_cut,
                                     bottom: rd_data.bottom};
              tile_nxt           = rd_data;
              tile_nxt.left      = left_cut;
              count_nxt          = count_r + 1'b1;
              res_nxt.out_right  = left_cut;
              res_nxt.out_bottom = top_cut;
              state_nxt          = S_SPLIT;
            end
          end else if (rd_idx_r == '0) begin
            res_nxt        = '0;
            res_nxt.status = ST_NO_FIT;
            state_nxt      = S_RESP;
          end
        end
      end
      S_MOVE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = IW'(count_r - 1'b1);
        count_nxt = count_r - 1'b1;
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = rd_data;
        state_nxt = S_RESP;
      end
      S_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = tile_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[design/guillotine_rect_allocator.sv]
// Top level of the guillotine rectangle allocator for a 2D texture atlas.
//
// Requests arrive on the in_ channel (valid/ready) as one item: allocate, free or
// reinitialize. Each item gives exactly one result item on the out_ channel.
// An allocate scans the free-tile table from the newest entry to the oldest, one
// entry per cycle through the table's single read port, and takes the first tile
// that fits. The scan covers at most MAX_TILES entries; an exact fit then moves the
// last entry into the freed slot (states S_MOVE_RD and S_MOVE_WR), and a split
// writes the trimmed tile back in state S_SPLIT before the result is registered.
// Free, init, the unused op and an allocate on an empty table go straight to S_RESP.
// One item is worked on at a time; the next item can be accepted in the cycle after
// the result is registered.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a stalled receiver holds the output register and
// the block stops before it would overwrite it.
// The atlas size registers sit behind the APB port and are used by init and at boot.
// After reset the block writes the full-atlas tile into entry zero in state S_BOOT
// with in_ready low; the table then holds that single tile.
`default_nettype none
module guillotine_rect_allocator #(
  parameter int MAX_TILES = gra_pkg::MAX_TILES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire gra_pkg::req_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output gra_pkg::res_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gra_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [gra_pkg::DATA_W-1:0]  pwdata,
  output logic      [gra_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import gra_pkg::*;

  localparam int IW = $clog2(MAX_TILES);

  cfg_t          cfg;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  tile_t         rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  tile_t         wr_data;

  gra_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gra_tile_mem #(
    .MAX_TILES (MAX_TILES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gra_ctrl #(
    .MAX_TILES (MAX_TILES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule
`default_nettype wire

[design/gra_checker.sv]
// Port-level checker of the allocator and the bind that attaches it to the top level.
`default_nettype none
module gra_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire gra_pkg::res_t out_data
);
  import gra_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // One item is worked on at a time, so ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // A failed request reports an all-zero rectangle.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_FIT || out_data.status == ST_FULL) |->
      out_data.out_left == '0 && out_data.out_top == '0 &&
      out_data.out_right == '0 && out_data.out_bottom == '0)
    else $error("failed request carries a nonzero rectangle");

endmodule

bind guillotine_rect_allocator gra_checker u_gra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the guillotine rectangle allocator: predicts each result and compares.
module tb;
  import gra_pkg::*;

  localparam int TILE_SLOTS = MAX_TILES_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tile_t free_tile [0:TILE_SLOTS-1];
  int free_count;
  coord_t atlas_w;
  coord_t atlas_h;
  res_t placement_q[$];
  tile_t granted_q[$];
  int mismatches = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  guillotine_rect_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic coord_t sat_coord(input coord_t v);
    return (v > 15'd16384) ? 15'd16384 : v;
  endfunction

  function automatic coord_t extent(input coord_t lo, input coord_t hi);
    return (hi > lo) ? coord_t'(hi - lo) : 15'd0;
  endfunction

  function automatic void reload_full_atlas();
    for (int i = 0; i < TILE_SLOTS; i++) free_tile[i] = '0;
    free_tile[0].right = atlas_w;
    free_tile[0].bottom = atlas_h;
    free_count = 1;
  endfunction

  function automatic res_t predict_placement(input req_t r);
    res_t res;
    tile_t t;
    coord_t tw, th, w, h;
    int n;
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_ALLOC: begin
        w = r.req_width;
        h = r.req_height;
        n = free_count;
        res.status = ST_NO_FIT;
        for (int i = n - 1; i >= 0; i--) begin
          t = free_tile[i];
          tw = extent(t.left, t.right);
          th = extent(t.top, t.bottom);
          if (w <= tw && h <= th) begin
            res.status = ST_OK;
            res.out_left = t.left;
            res.out_top = t.top;
            if (w == tw && h == th) begin
              res.out_right = t.right;
              res.out_bottom = t.bottom;
              free_tile[i] = free_tile[n-1];
              free_tile[n-1] = '0;
              free_count = n - 1;
            end else if (w == tw) begin
              res.out_right = t.right;
              res.out_bottom = t.top + h;
              free_tile[i].top = t.top + h;
            end else if (h == th) begin
              res.out_right = t.left + w;
              res.out_bottom = t.bottom;
              free_tile[i].left = t.left + w;
            end else if (n >= TILE_SLOTS) begin
              res = '0;
              res.status = ST_FULL;
            end else begin
              free_tile[n].left = t.left;
              free_tile[n].top = t.top + h;
              free_tile[n].right = t.left + w;
              free_tile[n].bottom = t.bottom;
              free_count = n + 1;
              free_tile[i].left = t.left + w;
              res.out_right = t.left + w;
              res.out_bottom = t.top + h;
            end
            return res;
          end
        end
      end
      OP_FREE: begin
        if (free_count >= TILE_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          free_tile[free_count].left = sat_coord(r.rect_left);
          free_tile[free_count].top = sat_coord(r.rect_top);
          free_tile[free_count].right = sat_coord(r.rect_right);
          free_tile[free_count].bottom = sat_coord(r.rect_bottom);
          free_count++;
        end
      end
      OP_INIT: reload_full_atlas();
      default: ;
    endcase
    return res;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, 32767));
  endfunction

  function automatic req_t build_req(input op_t op, input int w, input int h, input int l,
                                     input int t, input int r, input int b);
    req_t q;
    q.op = op;
    q.req_width = coord_t'(w);
    q.req_height = coord_t'(h);
    q.rect_left = coord_t'(l);
    q.rect_top = coord_t'(t);
    q.rect_right = coord_t'(r);
    q.rect_bottom = coord_t'(b);
    return q;
  endfunction

  function automatic req_t random_request();
    req_t q;
    tile_t t;
    coord_t tw, th;
    int pick, s, j, lo;
    q = build_req(OP_NOP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (pick < 60) begin
      q.op = OP_ALLOC;
      if (s < 35 && free_count > 0) begin
        j = $urandom_range(0, free_count - 1);
        t = free_tile[j];
        tw = extent(t.left, t.right);
        th = extent(t.top, t.bottom);
        q.req_width = coord_t'($urandom_range(0, tw));
        q.req_height = coord_t'($urandom_range(0, th));
        case ($urandom_range(0, 3))
          0: begin
            q.req_width = tw;
            q.req_height = th;
          end
          1: begin
            q.req_width = tw;
            if (th > 0) q.req_height = coord_t'($urandom_range(0, th - 1));
          end
          2: begin
            q.req_height = th;
            if (tw > 0) q.req_width = coord_t'($urandom_range(0, tw - 1));
          end
          default: ;
        endcase
      end else if (s < 80) begin
        q.req_width = coord_t'($urandom_range(0, atlas_w / 8 + 1));
        q.req_height = coord_t'($urandom_range(0, atlas_h / 8 + 1));
      end else if (s < 92) begin
        q.req_width = coord_t'($urandom_range(0, atlas_w));
        q.req_height = coord_t'($urandom_range(0, atlas_h));
      end
    end else if (pick < 95) begin
      q.op = OP_FREE;
      if (s < 45 && granted_q.size() > 0) begin
        j = $urandom_range(0, granted_q.size() - 1);
        t = granted_q[j];
        granted_q.delete(j);
        q.rect_left = t.left;
        q.rect_top = t.top;
        q.rect_right = t.right;
        q.rect_bottom = t.bottom;
      end else if (s < 85) begin
        lo = $urandom_range(0, 16384);
        q.rect_left = coord_t'(lo);
        q.rect_right = coord_t'($urandom_range(lo, 16384));
        lo = $urandom_range(0, 16384);
        q.rect_top = coord_t'(lo);
        q.rect_bottom = coord_t'($urandom_range(lo, 16384));
      end
    end else if (pick < 97) begin
      q.op = OP_INIT;
    end
    return q;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    $display("tb: mismatch on %s: got %0d, expected %0d", field, got, exp_val);
  endtask

  task automatic offer(input req_t r);
    res_t res;
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_placement(r);
    placement_q.insert(placement_q.size(), res);
    if (r.op == OP_INIT) granted_q.delete();
    if (r.op == OP_ALLOC && res.status == ST_OK) begin
      granted_q.insert(granted_q.size(),
                       {res.out_left, res.out_top, res.out_right, res.out_bottom});
      if (granted_q.size() > 256) void'(granted_q.pop_front());
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_atlas_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ATLAS_W) atlas_w = sat_coord(value[COORD_W-1:0]);
    else atlas_h = sat_coord(value[COORD_W-1:0]);
    @(posedge clk);
  endtask

  task automatic test_directed();
    offer(build_req(OP_ALLOC, 4096, 4096, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_FREE, 0, 0, 0, 0, 4096, 4096));
    offer(build_req(OP_ALLOC, 4096, 100, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 100, 3996, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 10, 10, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_FREE, 0, 0, 100, 100, 50, 50));
    offer(build_req(OP_ALLOC, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_FREE, 0, 0, 32767, 20000, 16385, 32767));
    offer(build_req(OP_ALLOC, 32767, 32767, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 16384, 16384, 0, 0, 0, 0));
    offer(build_req(OP_NOP, 32767, 32767, 32767, 32767, 32767, 32767));
    offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
    settle();
    write_atlas_reg(REG_ATLAS_W, 32'd1);
    write_atlas_reg(REG_ATLAS_H, 32'd1);
    offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 1, 1, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 0, 0, 0, 0, 0, 0));
    settle();
    write_atlas_reg(REG_ATLAS_W, 32'h0000_7FFF);
    write_atlas_reg(REG_ATLAS_H, 32'd16384);
    offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 16384, 16384, 0, 0, 0, 0));
    settle();
    write_atlas_reg(REG_ATLAS_W, 32'hFFFF_0007);
    offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 3, 16384, 0, 0, 0, 0));
    settle();
  endtask

  task automatic test_table_full();
    int l, t;
    write_atlas_reg(REG_ATLAS_W, 32'd16384);
    write_atlas_reg(REG_ATLAS_H, 32'd16384);
    offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
    repeat (70) begin
      l = $urandom_range(0, 16284);
      t = $urandom_range(0, 16284);
      offer(build_req(OP_FREE, rand_coord(), rand_coord(), l, t, l + 100, t + 100));
    end
    offer(build_req(OP_ALLOC, 10, 10, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 100, 100, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 10, 10, 0, 0, 0, 0));
    offer(build_req(OP_ALLOC, 5, 5, 0, 0, 0, 0));
    offer(build_req(OP_FREE, 0, 0, 1, 2, 3, 4));
    settle();
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    burst_left = 20;
    repeat (12) offer(random_request());
    settle();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          write_atlas_reg(REG_ATLAS_W, 32'd16384);
          write_atlas_reg(REG_ATLAS_H, 32'd16384);
        end
        1: begin
          write_atlas_reg(REG_ATLAS_W, 32'd2);
          write_atlas_reg(REG_ATLAS_H, 32'd300);
        end
        2: begin
          write_atlas_reg(REG_ATLAS_W, 32'h0000_7FFF);
          write_atlas_reg(REG_ATLAS_H, 32'd5000);
        end
        3: begin
          write_atlas_reg(REG_ATLAS_W, 32'd64);
          write_atlas_reg(REG_ATLAS_H, 32'd64);
        end
        4: begin
          write_atlas_reg(REG_ATLAS_W, $urandom_range(1, 16384));
          write_atlas_reg(REG_ATLAS_H, $urandom_range(1, 16384));
        end
        default: begin
          write_atlas_reg(REG_ATLAS_W, $urandom);
          write_atlas_reg(REG_ATLAS_H, $urandom);
        end
      endcase
      offer(build_req(OP_INIT, 0, 0, 0, 0, 0, 0));
      repeat (210) offer(random_request());
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_left % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = placement_q.pop_front();
        if (out_data.out_left !== want.out_left)
          report_mismatch("out_left", 32'(out_data.out_left), 32'(want.out_left));
        if (out_data.out_top !== want.out_top)
          report_mismatch("out_top", 32'(out_data.out_top), 32'(want.out_top));
        if (out_data.out_right !== want.out_right)
          report_mismatch("out_right", 32'(out_data.out_right), 32'(want.out_right));
        if (out_data.out_bottom !== want.out_bottom)
          report_mismatch("out_bottom", 32'(out_data.out_bottom), 32'(want.out_bottom));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  initial begin
    atlas_w = ATLAS_RESET;
    atlas_h = ATLAS_RESET;
    reload_full_atlas();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_output_backpressure();
    test_random_phases();
    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && placement_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[guillotine_rect_allocator.f]
design/gra_pkg.sv
design/gra_regs.sv
design/gra_tile_mem.sv
design/gra_ctrl.sv
design/guillotine_rect_allocator.sv
design/gra_checker.sv
tb/sv/tb.sv
